[hdl/adpcm4e_pkg.sv]
`default_nettype none

package adpcm4e_pkg;

    localparam int PCM_W   = 16;
    localparam int DIFF_W  = 17;
    localparam int STEP_W  = 15;
    localparam int REM_W   = 18;
    localparam int SCALE_W = 10;
    localparam int DPROD_W = 19;
    localparam int NPROD_W = 25;

    localparam logic signed [DIFF_W-1:0] PCM_MAX_X = 17'sd32767;
    localparam logic signed [DIFF_W-1:0] PCM_MIN_X = -17'sd32768;
    localparam logic [PCM_W-1:0]         D_MAX     = 16'd32767;
    localparam logic [STEP_W-1:0]        STEP_MIN  = 15'd127;
    localparam logic [STEP_W-1:0]        STEP_MAX  = 15'd24576;

    typedef struct packed {
        logic load;
        logic abs_en;
        logic div_en;
        logic mul_en;
        logic upd_en;
        logic emit_en;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
        logic emit_ok;
    } dp_stat_t;

    function automatic logic [SCALE_W-1:0] step_scale(input logic [2:0] mag);
        logic [SCALE_W-1:0] t;
        case (mag)
            3'd4:    t = 10'd307;
            3'd5:    t = 10'd409;
            3'd6:    t = 10'd512;
            3'd7:    t = 10'd614;
            default: t = 10'd230;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[hdl/adpcm4e_if.sv]
`default_nettype none

interface adpcm4e_pcm_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  sample;
    logic                last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface adpcm4e_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  packed_byte;
    logic        last_byte;

    modport source (output valid, output packed_byte, output last_byte, input ready);
    modport sink   (input valid, input packed_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[hdl/adpcm_4bit_encoder.sv]
// 4-bit ADPCM encoder: each accepted 16-bit PCM sample becomes a 4-bit code
// (sign plus 3-bit magnitude of 4*|sample - prediction| / step, capped at 7),
// and codes are packed two per byte, earlier code in the low nibble. A sample
// marked last_sample ends the stream: it completes the byte of a held code or
// else flushes a lone code with a zero high nibble, flags last_byte, and
// returns the predictor to its reset state. A new sample is taken only in the
// idle state, once the last one is packed; in between come the absolute
// difference, the restoring divider that forms the quotient a bit per cycle,
// the step multipliers, the predictor update and the pack. The pack waits
// while the output register holds a byte not yet taken and a new byte is due.
`default_nettype none

module adpcm_4bit_encoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    adpcm4e_pcm_if.sink     pcm,
    adpcm4e_byte_if.source  code
);

    adpcm4e_pkg::dp_cmd_t  cmd;
    adpcm4e_pkg::dp_stat_t stat;

    adpcm4e_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pcm.valid),
        .in_ready (pcm.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    adpcm4e_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .sample      (pcm.sample),
        .last_sample (pcm.last_sample),
        .out_valid   (code.valid),
        .out_ready   (code.ready),
        .packed_byte (code.packed_byte),
        .last_byte   (code.last_byte)
    );

endmodule

`default_nettype wire

[hdl/adpcm4e_ctrl.sv]
`default_nettype none

module adpcm4e_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire adpcm4e_pkg::dp_stat_t stat,
    output adpcm4e_pkg::dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ABS  = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_ABS;
            ST_ABS:  state_next = ST_DIV;
            ST_DIV:  if (stat.div_last) state_next = ST_MUL;
            ST_MUL:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_EMIT;
            ST_EMIT: if (stat.emit_ok) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign cmd.load    = (state_reg == ST_IDLE) && in_valid;
    assign cmd.abs_en  = (state_reg == ST_ABS);
    assign cmd.div_en  = (state_reg == ST_DIV);
    assign cmd.mul_en  = (state_reg == ST_MUL);
    assign cmd.upd_en  = (state_reg == ST_UPD);
    assign cmd.emit_en = (state_reg == ST_EMIT) && stat.emit_ok;

endmodule

`default_nettype wire

[hdl/adpcm4e_dp.sv]
`default_nettype none

module adpcm4e_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire adpcm4e_pkg::dp_cmd_t  cmd,
    output adpcm4e_pkg::dp_stat_t      stat,
    input  wire logic signed [15:0]    sample,
    input  wire logic                  last_sample,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 packed_byte,
    output logic                       last_byte
);

    // predictor and packing state
    logic signed [adpcm4e_pkg::PCM_W-1:0]  pred_reg, pred_next;
    logic [adpcm4e_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [3:0]                            held_reg, held_next;
    logic                                  pend_reg, pend_next;
    logic                                  ovalid_reg, ovalid_next;

    // per-sample working registers
    logic                                  last_reg;
    logic signed [adpcm4e_pkg::DIFF_W-1:0] diff_reg;
    logic                                  neg_reg;
    logic [adpcm4e_pkg::REM_W-1:0]         rem_reg;
    logic [1:0]                            cnt_reg;
    logic [3:0]                            quo_reg;
    logic [adpcm4e_pkg::DPROD_W-1:0]       dprod_reg;
    logic [adpcm4e_pkg::NPROD_W-1:0]       nprod_reg;
    logic [7:0]                            obyte_reg;
    logic                                  olast_reg;

    logic signed [adpcm4e_pkg::DIFF_W-1:0] adiff;
    logic [adpcm4e_pkg::REM_W-1:0]         dvsr;
    logic                                  fits;
    logic [2:0]                            mag;
    logic [3:0]                            code;
    logic [adpcm4e_pkg::PCM_W-1:0]         dsh;
    logic [adpcm4e_pkg::PCM_W-1:0]         dlim;
    logic signed [adpcm4e_pkg::DIFF_W-1:0] psum;
    logic [adpcm4e_pkg::DIFF_W-1:0]        nsh;
    logic                                  need_out;
    logic                                  out_free;

    assign adiff = diff_reg[adpcm4e_pkg::DIFF_W-1] ? -diff_reg : diff_reg;
    assign dvsr  = {3'd0, step_reg} << cnt_reg;
    assign fits  = (rem_reg >= dvsr);
    assign mag   = quo_reg[3] ? 3'd7 : quo_reg[2:0];
    assign code  = {neg_reg, mag};

    assign dsh  = dprod_reg[adpcm4e_pkg::DPROD_W-1:3];
    assign dlim = (dsh > adpcm4e_pkg::D_MAX) ? adpcm4e_pkg::D_MAX : dsh;
    assign psum = neg_reg ? ({pred_reg[15], pred_reg} - $signed({1'b0, dlim}))
                          : ({pred_reg[15], pred_reg} + $signed({1'b0, dlim}));
    assign nsh  = nprod_reg[adpcm4e_pkg::NPROD_W-1:8];

    assign need_out = pend_reg || last_reg;
    assign out_free = !ovalid_reg || out_ready;

    assign stat.div_last = (cnt_reg == 2'd0);
    assign stat.emit_ok  = !need_out || out_free;

    always_comb
    begin
        pred_next   = pred_reg;
        step_next   = step_reg;
        held_next   = held_reg;
        pend_next   = pend_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        if (cmd.upd_en)
        begin
            if (psum > adpcm4e_pkg::PCM_MAX_X)
                pred_next = adpcm4e_pkg::PCM_MAX_X[15:0];
            else if (psum < adpcm4e_pkg::PCM_MIN_X)
                pred_next = adpcm4e_pkg::PCM_MIN_X[15:0];
            else
                pred_next = psum[15:0];
            if (nsh < {2'b00, adpcm4e_pkg::STEP_MIN})
                step_next = adpcm4e_pkg::STEP_MIN;
            else if (nsh > {2'b00, adpcm4e_pkg::STEP_MAX})
                step_next = adpcm4e_pkg::STEP_MAX;
            else
                step_next = nsh[adpcm4e_pkg::STEP_W-1:0];
        end
        if (cmd.emit_en)
        begin
            if (need_out)
                ovalid_next = 1'b1;
            if (pend_reg)
                pend_next = 1'b0;
            else if (!last_reg)
            begin
                held_next = code;
                pend_next = 1'b1;
            end
            // end of stream: start fresh
            if (last_reg)
            begin
                pred_next = '0;
                step_next = adpcm4e_pkg::STEP_MIN;
                held_next = '0;
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg   <= '0;
            step_reg   <= adpcm4e_pkg::STEP_MIN;
            held_reg   <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            pred_reg   <= pred_next;
            step_reg   <= step_next;
            held_reg   <= held_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            diff_reg <= {sample[15], sample} - {pred_reg[15], pred_reg};
            last_reg <= last_sample;
        end
        if (cmd.abs_en)
        begin
            neg_reg <= diff_reg[adpcm4e_pkg::DIFF_W-1];
            rem_reg <= {adiff[15:0], 2'b00};
            cnt_reg <= 2'd3;
            quo_reg <= '0;
        end
        if (cmd.div_en)
        begin
            if (fits)
                rem_reg <= rem_reg - dvsr;
            quo_reg <= {quo_reg[2:0], fits};
            cnt_reg <= cnt_reg - 2'd1;
        end
        if (cmd.mul_en)
        begin
            dprod_reg <= {15'd0, mag, 1'b1} * {4'd0, step_reg};
            nprod_reg <= {15'd0, adpcm4e_pkg::step_scale(mag)} * {10'd0, step_reg};
        end
        if (cmd.emit_en && need_out)
        begin
            obyte_reg <= pend_reg ? {code, held_reg} : {4'd0, code};
            olast_reg <= last_reg;
        end
    end

    assign out_valid   = ovalid_reg;
    assign packed_byte = obyte_reg;
    assign last_byte   = olast_reg;

endmodule

`default_nettype wire

[hdl/adpcm4e_chk.sv]
`default_nettype none

module adpcm4e_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_last
);

    // one sample at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a sample is in work");

    // a byte never appears right after an input transfer
    a_byte_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("byte produced too soon after a sample transfer");

    // a valid byte carries known bits
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({out_byte, out_last}))
        else $error("unknown byte on output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled byte changed");

endmodule

bind adpcm_4bit_encoder adpcm4e_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pcm.valid),
    .in_ready  (pcm.ready),
    .out_valid (code.valid),
    .out_ready (code.ready),
    .out_byte  (code.packed_byte),
    .out_last  (code.last_byte)
);

`default_nettype wire

[test/adpcm4e_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module adpcm4e_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    adpcm4e_pcm_if      pcm,
    adpcm4e_byte_if     code,
    output int          mismatches,
    output int          bytes_owed
);

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
    } coded_byte_t;

    coded_byte_t expected_bytes[$];
    int          est_level;
    int          cur_step;
    logic [3:0]  held_nibble;
    logic        nibble_held;
    int          error_count;

    function automatic void encode_sample(input logic signed [15:0] pcm_val,
                                          input logic end_of_stream);
        int          diff;
        int          adiff;
        int          mag;
        int          delta;
        int          level;
        int          factor;
        int          next_step;
        logic [3:0]  nib;
        coded_byte_t cb;

        diff  = int'(pcm_val) - est_level;
        adiff = (diff < 0) ? -diff : diff;
        mag   = (4 * adiff) / cur_step;
        if (mag > 7)
            mag = 7;
        nib = {diff < 0, mag[2:0]};

        if (nibble_held)
        begin
            cb.packed_byte = {nib, held_nibble};
            cb.last_byte   = end_of_stream;
            expected_bytes.push_back(cb);
            nibble_held = 1'b0;
        end
        else if (end_of_stream)
        begin
            cb.packed_byte = {4'd0, nib};
            cb.last_byte   = 1'b1;
            expected_bytes.push_back(cb);
        end
        else
        begin
            held_nibble = nib;
            nibble_held = 1'b1;
        end

        // decoder-side step and level update
        delta = ((1 + 2 * mag) * cur_step) >>> 3;
        if (delta > 32767)
            delta = 32767;
        level = nib[3] ? est_level - delta : est_level + delta;
        if (level > 32767)
            level = 32767;
        if (level < -32768)
            level = -32768;
        est_level = level;

        case (mag)
            4:       factor = 307;
            5:       factor = 409;
            6:       factor = 512;
            7:       factor = 614;
            default: factor = 230;
        endcase
        next_step = (factor * cur_step) >>> 8;
        if (next_step < 127)
            next_step = 127;
        if (next_step > 24576)
            next_step = 24576;
        cur_step = next_step;

        if (end_of_stream)
        begin
            est_level   = 0;
            cur_step    = 127;
            held_nibble = 4'd0;
            nibble_held = 1'b0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        coded_byte_t want;
        if (!rst_n)
        begin
            expected_bytes.delete();
            est_level   = 0;
            cur_step    = 127;
            held_nibble = 4'd0;
            nibble_held = 1'b0;
            error_count = 0;
            mismatches <= 0;
            bytes_owed <= 0;
        end
        else
        begin
            if (code.valid && code.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("packed_byte: expected none, got %h", code.packed_byte);
                    error_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (code.packed_byte !== want.packed_byte)
                    begin
                        $error("packed_byte: expected %h, got %h",
                               want.packed_byte, code.packed_byte);
                        error_count++;
                    end
                    if (code.last_byte !== want.last_byte)
                    begin
                        $error("last_byte: expected %b, got %b",
                               want.last_byte, code.last_byte);
                        error_count++;
                    end
                end
            end
            if (pcm.valid && pcm.ready)
                encode_sample(pcm.sample, pcm.last_sample);
            mismatches <= error_count;
            bytes_owed <= expected_bytes.size();
        end
    end

endmodule

`default_nettype wire

[test/tb_adpcm_4bit_encoder.sv]
`timescale 1ns / 1ps
`default_nettype none

module tb_adpcm_4bit_encoder;

    localparam int RANDOM_ITEMS   = 850;
    localparam int QUIET_AFTER    = 700;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DIRECTED_ITEMS = 21;

    typedef enum {WAVE_WALK, WAVE_NOISE, WAVE_SWING, WAVE_HOLD} wave_kind_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   bytes_owed;
    int   cycles;
    logic quiet;
    logic gaps_on;

    adpcm4e_pcm_if  pcm_ch ();
    adpcm4e_byte_if byte_ch ();

    adpcm_4bit_encoder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pcm   (pcm_ch.sink),
        .code  (byte_ch.source)
    );

    adpcm4e_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pcm        (pcm_ch),
        .code       (byte_ch),
        .mismatches (mismatches),
        .bytes_owed (bytes_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // output side back-pressure
    initial
    begin
        byte_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && gaps_on && $urandom_range(0, 7) == 0)
            begin
                byte_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            byte_ch.ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic signed [15:0] pcm_val, input logic fin);
        pcm_ch.valid       <= 1'b1;
        pcm_ch.sample      <= pcm_val;
        pcm_ch.last_sample <= fin;
        do
            @(posedge clk);
        while (!pcm_ch.ready);
        if (!quiet && gaps_on && $urandom_range(0, 3) == 0)
        begin
            pcm_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic drain_bytes();
        @(posedge clk);
        @(posedge clk);
        while (bytes_owed != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [15:0] directed_pcm[DIRECTED_ITEMS];
        logic               directed_end[DIRECTED_ITEMS];
        int                 sent;
        int                 run_len;
        int                 level;
        wave_kind_t         wave;
        logic signed [15:0] pcm_val;

        directed_pcm = '{
            16'sd0,
            16'sd32767, -16'sd32768,
            16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
            -16'sd32768, -16'sd32768, -16'sd32768, 16'sd0,
            16'sd0, 16'sd0, -16'sd1,
            16'sd1, -16'sd1, 16'sd2, -16'sd2, 16'sd0
        };
        directed_end = '{
            1'b1,
            1'b0, 1'b1,
            1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
            1'b0, 1'b0, 1'b0, 1'b1,
            1'b0, 1'b0, 1'b1,
            1'b0, 1'b0, 1'b0, 1'b0, 1'b1
        };

        quiet   = 1'b0;
        gaps_on = 1'b1;
        rst_n              <= 1'b0;
        pcm_ch.valid       <= 1'b0;
        pcm_ch.sample      <= '0;
        pcm_ch.last_sample <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_pcm[i])
            send_sample(directed_pcm[i], directed_end[i]);

        // hold off until every byte so far is out
        pcm_ch.valid <= 1'b0;
        drain_bytes();

        sent  = 0;
        level = 0;
        while (sent < RANDOM_ITEMS)
        begin
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 40);
            wave    = wave_kind_t'($urandom_range(0, 3));
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < run_len; k++)
            begin
                quiet = (sent >= QUIET_AFTER);
                if ($urandom_range(0, 9) == 0)
                    wave = wave_kind_t'($urandom_range(0, 3));
                case (wave)
                    WAVE_WALK:
                    begin
                        level = level + $signed($urandom_range(0, 4000)) - 2000;
                        if (level > 32767)
                            level = 32767;
                        if (level < -32768)
                            level = -32768;
                    end
                    WAVE_NOISE:
                        level = $signed($urandom_range(0, 65535)) - 32768;
                    WAVE_SWING:
                        level = ($urandom_range(0, 1) != 0)
                              ? 32767 - $signed($urandom_range(0, 255))
                              : -32768 + $signed($urandom_range(0, 255));
                    default: ;
                endcase
                pcm_val = level[15:0];
                send_sample(pcm_val, (k == run_len - 1));
                sent++;
            end
        end

        pcm_ch.valid <= 1'b0;
        drain_bytes();
        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
